// ===== rtl/mkpsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkpsd_pkg
// Shared constants, key map and types for the keypad scanner with debounce.
// ----------------------------------------------------------------------------
package mkpsd_pkg;

    localparam int ROWS_DEF    = 4;
    localparam int COLUMNS_DEF = 4;

    localparam int COL_IN_W    = 4;
    localparam int INTEG_W     = 4;
    localparam int ROW_SEL_W   = 2;
    localparam int CODE_W      = 4;
    localparam int VALUE_W     = 4;
    localparam int CODE_FULL_W = 8;

    localparam logic [INTEG_W-1:0] LIMIT_RESET = 4'd4;
    localparam logic [INTEG_W-1:0] LIMIT_MIN   = 4'd1;

    localparam logic [VALUE_W-1:0] KEY_MAP [16] = '{
        4'd10, 4'd3,  4'd2, 4'd1,
        4'd11, 4'd6,  4'd5, 4'd4,
        4'd12, 4'd9,  4'd8, 4'd7,
        4'd13, 4'd14, 4'd0, 4'd15
    };

    typedef struct packed {
        logic               hit;
        logic [CODE_W-1:0]  code;
        logic [VALUE_W-1:0] value;
    } mkpsd_key_t;

    function automatic int addr_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

// ===== rtl/mkpsd_row_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkpsd_row_mem
// Per-row key state memory with row valid bits and write-to-read forwarding.
// ----------------------------------------------------------------------------
module mkpsd_row_mem #(
    parameter int ROWS    = mkpsd_pkg::ROWS_DEF,
    parameter int COLUMNS = mkpsd_pkg::COLUMNS_DEF,
    localparam int ROW_W   = mkpsd_pkg::addr_w(ROWS),
    localparam int ENTRY_W = COLUMNS * (mkpsd_pkg::INTEG_W + 2)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [ROW_W-1:0]   rd_addr,
    input  logic               wr_en,
    input  logic [ROW_W-1:0]   wr_addr,
    input  logic [ENTRY_W-1:0] wr_data,
    output logic [ENTRY_W-1:0] rd_data
);
    import mkpsd_pkg::*;

    localparam logic [ENTRY_W-1:0] RESET_ENTRY =
        {{COLUMNS{1'b0}}, {COLUMNS{1'b1}}, {COLUMNS{LIMIT_RESET}}};

    logic [ENTRY_W-1:0] mem [ROWS];
    logic [ROWS-1:0]    valid_reg;
    logic [ENTRY_W-1:0] rd_mem_reg;
    logic [ENTRY_W-1:0] rd_fwd_data_reg;
    logic               rd_fwd_reg;
    logic               rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_mem_reg      <= mem[rd_addr];
        rd_fwd_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_fwd_reg   <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_fwd_reg   <= wr_en && (wr_addr == rd_addr);
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_comb
    begin
        if (rd_fwd_reg)
        begin
            rd_data = rd_fwd_data_reg;
        end
        else if (rd_valid_reg)
        begin
            rd_data = rd_mem_reg;
        end
        else
        begin
            rd_data = RESET_ENTRY;
        end
    end

endmodule

// ===== rtl/mkpsd_row_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkpsd_row_update
// Debounce one row of keys up to its first new press, pick that press and the next row.
// ----------------------------------------------------------------------------
module mkpsd_row_update #(
    parameter int ROWS    = mkpsd_pkg::ROWS_DEF,
    parameter int COLUMNS = mkpsd_pkg::COLUMNS_DEF,
    localparam int ROW_W   = mkpsd_pkg::addr_w(ROWS)
) (
    input  logic [ROW_W-1:0]                           row,
    input  logic [mkpsd_pkg::INTEG_W-1:0]              limit,
    input  logic [mkpsd_pkg::COL_IN_W-1:0]             column_levels,
    input  logic [COLUMNS-1:0][mkpsd_pkg::INTEG_W-1:0] integ_in,
    input  logic [COLUMNS-1:0]                         lvl_in,
    input  logic [COLUMNS-1:0]                         rep_in,
    output logic [COLUMNS-1:0][mkpsd_pkg::INTEG_W-1:0] integ_out,
    output logic [COLUMNS-1:0]                         lvl_out,
    output logic [COLUMNS-1:0]                         rep_out,
    output mkpsd_pkg::mkpsd_key_t                      key,
    output logic [ROW_W-1:0]                           next_row
);
    import mkpsd_pkg::*;

    localparam int COL_W = addr_w(COLUMNS);

    logic [INTEG_W-1:0]     eff_lim;
    logic [COLUMNS-1:0]     cand;
    logic [COLUMNS-1:0]     blocked;
    logic [COL_W-1:0]       hit_col;
    logic [CODE_FULL_W-1:0] code_full;
    logic [CODE_W-1:0]      code;

    assign eff_lim = (limit == '0) ? LIMIT_MIN : limit;

    for (genvar c = 0; c < COLUMNS; c++)
    begin : g_col
        logic               rel;
        logic [INTEG_W-1:0] v;
        logic               lvl;

        if (c < COL_IN_W)
        begin : g_pin
            assign rel = column_levels[c];
        end
        else
        begin : g_none
            assign rel = 1'b1;
        end

        always_comb
        begin
            v   = integ_in[c];
            lvl = lvl_in[c];
            if (!rel)
            begin
                if (v != '0)
                begin
                    v = v - 1'b1;
                end
            end
            else if (v < eff_lim)
            begin
                v = v + 1'b1;
            end
            if (v == '0)
            begin
                lvl = 1'b0;
            end
            else if (v >= eff_lim)
            begin
                v   = eff_lim;
                lvl = 1'b1;
            end
        end

        assign cand[c] = !lvl && !rep_in[c];

        if (c == 0)
        begin : g_first
            assign blocked[c] = 1'b0;
        end
        else
        begin : g_rest
            assign blocked[c] = blocked[c-1] | cand[c-1];
        end

        always_comb
        begin
            if (blocked[c])
            begin
                integ_out[c] = integ_in[c];
                lvl_out[c]   = lvl_in[c];
                rep_out[c]   = rep_in[c];
            end
            else
            begin
                integ_out[c] = v;
                lvl_out[c]   = lvl;
                rep_out[c]   = cand[c] ? 1'b1 : (lvl ? 1'b0 : rep_in[c]);
            end
        end
    end

    always_comb
    begin
        hit_col = '0;
        for (int c = COLUMNS - 1; c >= 0; c--)
        begin
            if (cand[c])
            begin
                hit_col = COL_W'(c);
            end
        end
    end

    assign code_full = CODE_FULL_W'(row) * CODE_FULL_W'(COLUMNS) + CODE_FULL_W'(hit_col);
    assign code      = code_full[CODE_W-1:0];

    always_comb
    begin
        key.hit   = |cand;
        key.code  = key.hit ? code : '0;
        key.value = key.hit ? KEY_MAP[code] : '0;
        if (key.hit)
        begin
            next_row = row;
        end
        else if (row == ROW_W'(ROWS - 1))
        begin
            next_row = '0;
        end
        else
        begin
            next_row = row + 1'b1;
        end
    end

endmodule

// ===== rtl/matrix_keypad_scanner_debounce_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_keypad_scanner_debounce_core
// Row-scanned key matrix with per-key integrator debounce and press report.
// ----------------------------------------------------------------------------
// Each accepted item's result is captured in the output register.
// Throughput: one item per cycle unless an unread output stalls in_ready; row
// state is read the cycle before at the next row, same-cycle write forwarded.
// Reset: asynchronous; limit returns to 4, scan row to 0, and every row
// reads as released with integrators at 4 until first written.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner_debounce_core #(
    parameter int ROWS    = mkpsd_pkg::ROWS_DEF,
    parameter int COLUMNS = mkpsd_pkg::COLUMNS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [mkpsd_pkg::INTEG_W-1:0]        cfg_write_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [mkpsd_pkg::COL_IN_W-1:0]       column_levels,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [mkpsd_pkg::ROW_SEL_W-1:0]      row_select,
    output logic                                 key_valid,
    output logic [mkpsd_pkg::CODE_W-1:0]         key_code,
    output logic [mkpsd_pkg::VALUE_W-1:0]        key_value
);
    import mkpsd_pkg::*;

    localparam int ROW_W   = addr_w(ROWS);
    localparam int ENTRY_W = COLUMNS * (INTEG_W + 2);

    logic [INTEG_W-1:0]                limit_reg;
    logic [ROW_W-1:0]                  scan_row_reg;
    logic [ROW_W-1:0]                  scan_row_next;
    logic                              out_valid_reg;
    logic [ROW_SEL_W-1:0]              row_select_reg;
    logic                              key_valid_reg;
    logic [CODE_W-1:0]                 key_code_reg;
    logic [VALUE_W-1:0]                key_value_reg;

    logic                              accept;
    logic [ENTRY_W-1:0]                rd_data;
    logic [ENTRY_W-1:0]                wr_data;
    logic [COLUMNS-1:0][INTEG_W-1:0]   rd_integ;
    logic [COLUMNS-1:0]                rd_lvl;
    logic [COLUMNS-1:0]                rd_rep;
    logic [COLUMNS-1:0][INTEG_W-1:0]   new_integ;
    logic [COLUMNS-1:0]                new_lvl;
    logic [COLUMNS-1:0]                new_rep;
    mkpsd_key_t                        key;
    logic [ROW_W-1:0]                  next_row;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign {rd_rep, rd_lvl, rd_integ} = rd_data;
    assign wr_data                    = {new_rep, new_lvl, new_integ};
    assign scan_row_next              = accept ? next_row : scan_row_reg;

    mkpsd_row_mem #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_row_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (scan_row_next),
        .wr_en   (accept),
        .wr_addr (scan_row_reg),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    mkpsd_row_update #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_row_update (
        .row           (scan_row_reg),
        .limit         (limit_reg),
        .column_levels (column_levels),
        .integ_in      (rd_integ),
        .lvl_in        (rd_lvl),
        .rep_in        (rd_rep),
        .integ_out     (new_integ),
        .lvl_out       (new_lvl),
        .rep_out       (new_rep),
        .key           (key),
        .next_row      (next_row)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            scan_row_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                limit_reg <= cfg_write_data;
            end
            scan_row_reg <= scan_row_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_select_reg <= ROW_SEL_W'(next_row);
            key_valid_reg  <= key.hit;
            key_code_reg   <= key.code;
            key_value_reg  <= key.value;
        end
    end

    assign out_valid  = out_valid_reg;
    assign row_select = row_select_reg;
    assign key_valid  = key_valid_reg;
    assign key_code   = key_code_reg;
    assign key_value  = key_value_reg;

endmodule

// ===== bench/matrix_keypad_scanner_debounce_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_keypad_scanner_debounce_core_test
// Self-checking bench for the keypad scanner. A short table of scan ticks
// walks reset, row wrap and the first and last key codes. It is followed by
// phases of held-key scans with bounce noise under several debounce limits,
// including zero, the top value and a lowered limit. Results are checked per
// field against typed entries or a scan predictor; both sides stall randomly.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner_debounce_core_test;

    import mkpsd_pkg::*;

    typedef struct packed {
        logic [ROW_SEL_W-1:0] row;
        logic                 valid;
        logic [CODE_W-1:0]    code;
        logic [VALUE_W-1:0]   value;
    } scan_result_t;

    typedef struct packed {
        logic [COL_IN_W-1:0] cols;
        logic                typed;
        scan_result_t        exp;
    } scan_row_t;

    localparam int DIRECTED_COUNT = 24;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_ITEMS    = 220;
    localparam int CYCLE_LIMIT    = 200000;

    localparam logic [VALUE_W-1:0] KEY_LEGEND [16] = '{
        4'd10, 4'd3,  4'd2, 4'd1,
        4'd11, 4'd6,  4'd5, 4'd4,
        4'd12, 4'd9,  4'd8, 4'd7,
        4'd13, 4'd14, 4'd0, 4'd15
    };

    localparam logic [INTEG_W-1:0] PHASE_LIMITS [PHASE_COUNT] = '{
        4'd0, 4'd15, 4'd1, 4'd9, 4'd15, 4'd3, 4'd2, 4'd7
    };

    localparam scan_row_t SCAN_TABLE [DIRECTED_COUNT] = '{
        '{4'hF, 1'b1, '{2'd1, 1'b0, 4'd0, 4'd0}},
        '{4'hF, 1'b1, '{2'd2, 1'b0, 4'd0, 4'd0}},
        '{4'hF, 1'b1, '{2'd3, 1'b0, 4'd0, 4'd0}},
        '{4'hF, 1'b1, '{2'd0, 1'b0, 4'd0, 4'd0}},
        '{4'hE, 1'b0, '0},
        '{4'hF, 1'b0, '0},
        '{4'hF, 1'b0, '0},
        '{4'h7, 1'b0, '0},
        '{4'hE, 1'b0, '0},
        '{4'hF, 1'b0, '0},
        '{4'hF, 1'b0, '0},
        '{4'h7, 1'b0, '0},
        '{4'hE, 1'b0, '0},
        '{4'hF, 1'b0, '0},
        '{4'hF, 1'b0, '0},
        '{4'h7, 1'b0, '0},
        '{4'hE, 1'b1, '{2'd0, 1'b1, 4'd0, 4'd10}},
        '{4'hE, 1'b1, '{2'd1, 1'b0, 4'd0, 4'd0}},
        '{4'hF, 1'b0, '0},
        '{4'hF, 1'b0, '0},
        '{4'h7, 1'b1, '{2'd3, 1'b1, 4'd15, 4'd15}},
        '{4'h0, 1'b0, '0},
        '{4'hF, 1'b0, '0},
        '{4'h8, 1'b0, '0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write_en;
    logic [INTEG_W-1:0]    cfg_write_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [COL_IN_W-1:0]   column_levels;
    logic                  out_valid;
    logic                  out_ready;
    logic [ROW_SEL_W-1:0]  row_select;
    logic                  key_valid;
    logic [CODE_W-1:0]     key_code;
    logic [VALUE_W-1:0]    key_value;

    logic [INTEG_W-1:0]    limit_now;
    logic [INTEG_W-1:0]    integrator [16];
    logic                  level [16];
    logic                  reported [16];
    logic [ROW_SEL_W-1:0]  row_now;
    logic [15:0]           held_keys;

    scan_result_t          pending_scans [$];
    int                    failures;
    int                    cycles;
    logic                  no_idle;

    matrix_keypad_scanner_debounce_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .column_levels  (column_levels),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .row_select     (row_select),
        .key_valid      (key_valid),
        .key_code       (key_code),
        .key_value      (key_value)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[matrix_keypad_scanner_debounce_core] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= no_idle || ($urandom_range(0, 99) >= 16);
    end

    // outputs and ready are stable mid-cycle; a high pair here is taken at the next edge
    always @(negedge clk)
    begin
        scan_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_scans.size() == 0)
            begin
                $error("result with no expectation: row_select %0d key_valid %0d", row_select,
                       key_valid);
                failures++;
            end
            else
            begin
                want = pending_scans.pop_front();
                if (row_select !== want.row)
                begin
                    $error("row_select expected %0d actual %0d", want.row, row_select);
                    failures++;
                end
                if (key_valid !== want.valid)
                begin
                    $error("key_valid expected %0d actual %0d", want.valid, key_valid);
                    failures++;
                end
                if (key_code !== want.code)
                begin
                    $error("key_code expected %0d actual %0d", want.code, key_code);
                    failures++;
                end
                if (key_value !== want.value)
                begin
                    $error("key_value expected %0d actual %0d", want.value, key_value);
                    failures++;
                end
            end
        end
    end

    task automatic clear_scanner();
        limit_now = LIMIT_RESET;
        for (int k = 0; k < 16; k++)
        begin
            integrator[k] = LIMIT_RESET;
            level[k]      = 1'b1;
            reported[k]   = 1'b0;
        end
        row_now = '0;
    endtask

    task automatic scan_tick(input logic [COL_IN_W-1:0] cols, output scan_result_t r);
        logic [INTEG_W-1:0] lim;
        logic [INTEG_W-1:0] v;
        logic [3:0]         k;
        logic               hit;
        lim = (limit_now == 0) ? 4'd1 : limit_now;
        hit = 1'b0;
        r   = '0;
        for (int c = 0; c < 4; c++)
        begin
            if (!hit)
            begin
                k = {row_now, 2'(c)};
                v = integrator[k];
                if (!cols[c])
                begin
                    if (v != 0)
                        v = v - 1'b1;
                end
                else if (v < lim)
                    v = v + 1'b1;
                if (v == 0)
                    level[k] = 1'b0;
                else if (v >= lim)
                begin
                    v        = lim;
                    level[k] = 1'b1;
                end
                integrator[k] = v;
                if (!level[k] && !reported[k])
                begin
                    reported[k] = 1'b1;
                    hit         = 1'b1;
                    r.row       = row_now;
                    r.valid     = 1'b1;
                    r.code      = k;
                    r.value     = KEY_LEGEND[k];
                end
                else if (level[k])
                    reported[k] = 1'b0;
            end
        end
        if (!hit)
        begin
            row_now = row_now + 1'b1;
            r.row   = row_now;
        end
    endtask

    task automatic send_scan(input logic [COL_IN_W-1:0] cols, input logic typed,
                             input scan_result_t typed_exp);
        scan_result_t predicted;
        while (!no_idle && $urandom_range(0, 99) < 16)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        scan_tick(cols, predicted);
        pending_scans.push_back(typed ? typed_exp : predicted);
        in_valid      <= 1'b1;
        column_levels <= cols;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
    endtask

    task automatic random_scan();
        logic [COL_IN_W-1:0] cols;
        if ($urandom_range(0, 39) == 0)
            held_keys[$urandom_range(0, 15)] ^= 1'b1;
        if ($urandom_range(0, 299) == 0)
            held_keys = '0;
        if ($urandom_range(0, 9) == 0)
            cols = COL_IN_W'($urandom_range(0, 15));
        else
        begin
            cols = ~held_keys[row_now*4 +: 4];
            if ($urandom_range(0, 15) == 0)
                cols[$urandom_range(0, 3)] ^= 1'b1;
        end
        send_scan(cols, 1'b0, '0);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_scans.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [INTEG_W-1:0] value);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        limit_now = value;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        in_valid       = 1'b0;
        column_levels  = '0;
        no_idle        = 1'b0;
        held_keys      = '0;
        clear_scanner();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_COUNT; i++)
            send_scan(SCAN_TABLE[i].cols, SCAN_TABLE[i].typed, SCAN_TABLE[i].exp);
        drain_results();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_limit(PHASE_LIMITS[p]);
            no_idle = (p == 3);
            for (int i = 0; i < PHASE_ITEMS; i++)
                random_scan();
            drain_results();
        end

        if (failures == 0)
            $display("[matrix_keypad_scanner_debounce_core] OK");
        else
            $display("[matrix_keypad_scanner_debounce_core] ERROR");
        $finish;
    end

endmodule
